/* sv/ttc_pkg.sv */
`default_nettype none
package ttc_pkg;

	// Run depth bound and the widths of the running sums that follow from it.
	localparam int MAX_SAMPLES = 4096;
	localparam int MIN_SAMPLES = 3;
	localparam int T_W         = 16;
	localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W       = T_W + CNT_W;
	localparam int SX_W        = 2 * CNT_W;
	localparam int SXX_W       = 3 * CNT_W;
	localparam int SXY_W       = T_W + 2 * CNT_W;
	localparam int SYY_W       = 2 * T_W + CNT_W;

	// Correlation format and the widths of the finishing arithmetic.
	localparam int THR_W       = 15;
	localparam int CORR_W      = 16;
	localparam int CORR_FRAC   = 14;
	localparam int MUL_W       = 64;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int DIV_W       = PROD_W + 2 * CORR_FRAC;
	localparam int CQ_W        = 2 * CORR_FRAC + 1;
	localparam int ROOT_W      = CORR_FRAC + 1;
	localparam int QCNT_W      = $clog2(CQ_W);
	localparam int OUT_W       = 40;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(8192);

	// Products formed by the shared multiplier, in the order they are needed.
	typedef enum logic [2:0] {
		OP_N_SXY  = 3'd0,
		OP_SX_SY  = 3'd1,
		OP_N_SXX  = 3'd2,
		OP_SX_SX  = 3'd3,
		OP_N_SYY  = 3'd4,
		OP_SY_SY  = 3'd5,
		OP_NUM_SQ = 3'd6,
		OP_DX_DY  = 3'd7
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    accept;
		logic    mul_start;
		mul_op_t mul_op;
		logic    div_start;
		logic    div_mean;
		logic    sqrt_start;
		logic    out_load;
	} ttc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic enough;
		logic dy_zero;
		logic mul_done;
		logic div_done;
		logic sqrt_done;
		logic out_free;
	} ttc_status_t;

endpackage
`default_nettype wire

/* sv/ttc_mul.sv */
`default_nettype none
module ttc_mul (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ttc_pkg::MUL_W-1:0]  a,
	input  wire logic [ttc_pkg::MUL_W-1:0]  b,
	output logic                            done,
	output logic [ttc_pkg::PROD_W-1:0]      product
);

	logic                        busy_q;
	logic                        done_q;
	logic [ttc_pkg::PROD_W-1:0]  a_q;
	logic [ttc_pkg::MUL_W-1:0]   b_q;
	logic [ttc_pkg::PROD_W-1:0]  acc_q;

	// Control: run until the multiplier bits are used up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (b_q == '0)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Shift-and-add datapath, one multiplier bit per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= ttc_pkg::PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule
`default_nettype wire

/* sv/ttc_div.sv */
`default_nettype none
module ttc_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [ttc_pkg::DIV_W-1:0]  num,
	input  wire logic [ttc_pkg::DIV_W-1:0]  den,
	input  wire logic [ttc_pkg::QCNT_W-1:0] last_bit,
	output logic                            done,
	output logic [ttc_pkg::CQ_W-1:0]        quot
);

	logic                        busy_q;
	logic                        done_q;
	logic [ttc_pkg::QCNT_W-1:0]  cnt_q;
	logic [ttc_pkg::DIV_W-1:0]   rem_q;
	logic [ttc_pkg::DIV_W-1:0]   den_q;
	logic [ttc_pkg::CQ_W-1:0]    quo_q;
	logic                        ge;

	// The divisor arrives already aligned to the top quotient bit.
	assign ge = (rem_q >= den_q);

	// Control: one quotient bit per cycle, counting down to bit zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= last_bit;
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Restoring compare and subtract.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			quo_q <= {quo_q[ttc_pkg::CQ_W-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule
`default_nettype wire

/* sv/ttc_datapath.sv */
`default_nettype none
module ttc_datapath (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire ttc_pkg::ttc_cmd_t         cmd,
	output ttc_pkg::ttc_status_t           status,
	input  wire logic [ttc_pkg::T_W-1:0]   thickness,
	input  wire logic                      cfg_we,
	input  wire logic [ttc_pkg::THR_W-1:0] cfg_wdata,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [ttc_pkg::OUT_W-1:0]      out_data
);

	// Run accumulators.
	logic [ttc_pkg::CNT_W-1:0]     count_q;
	logic [ttc_pkg::SUM_W-1:0]     sum_q;
	logic [ttc_pkg::SXY_W-1:0]     sxy_q;
	logic [ttc_pkg::SYY_W-1:0]     syy_q;
	logic [ttc_pkg::SX_W-1:0]      sx_q;
	logic [ttc_pkg::SXX_W-1:0]     sxx_q;
	logic                          drop_q;
	logic [ttc_pkg::CNT_W+ttc_pkg::T_W-1:0] idx_t;
	logic [2*ttc_pkg::CNT_W-1:0]   idx_sq;
	logic [2*ttc_pkg::T_W-1:0]     t_sq;
	logic                          full;

	// Finishing registers.
	logic [ttc_pkg::THR_W-1:0]     thr_q;
	logic [ttc_pkg::MUL_W-1:0]     a_q;
	logic [ttc_pkg::MUL_W-1:0]     num_q;
	logic                          neg_q;
	logic [ttc_pkg::MUL_W-1:0]     dx_q;
	logic [ttc_pkg::MUL_W-1:0]     dy_q;
	logic                          dy_zero_q;
	logic [ttc_pkg::PROD_W-1:0]    nn_q;
	logic [ttc_pkg::PROD_W-1:0]    dd_q;
	logic [ttc_pkg::CQ_W-1:0]      cq_q;
	logic [ttc_pkg::T_W-1:0]       mean_q;

	// Shared units.
	logic [ttc_pkg::MUL_W-1:0]     mul_a;
	logic [ttc_pkg::MUL_W-1:0]     mul_b;
	logic                          mul_done;
	logic [ttc_pkg::PROD_W-1:0]    prod;
	logic [ttc_pkg::MUL_W-1:0]     prod_lo;
	logic [ttc_pkg::DIV_W-1:0]     div_num;
	logic [ttc_pkg::DIV_W-1:0]     div_den;
	logic [ttc_pkg::QCNT_W-1:0]    div_last;
	logic                          div_done;
	logic [ttc_pkg::CQ_W-1:0]      div_quot;

	// Root unit.
	logic [ttc_pkg::ROOT_W-1:0]    root_q;
	logic [ttc_pkg::ROOT_W-1:0]    sbit_q;
	logic                          sqrt_busy_q;
	logic                          sqrt_done_q;
	logic [ttc_pkg::ROOT_W-1:0]    cand;
	logic [2*ttc_pkg::ROOT_W-1:0]  cand_sq;

	// Result register.
	logic                          out_valid_q;
	logic [ttc_pkg::OUT_W-1:0]     out_data_q;
	logic                          enough;
	logic [ttc_pkg::ROOT_W-1:0]    qv;
	logic                          positive;
	logic                          trend_hit;
	logic [ttc_pkg::CORR_W-1:0]    corr;

	// Per-sample terms.
	assign full   = (count_q == ttc_pkg::CNT_W'(ttc_pkg::MAX_SAMPLES));
	assign idx_t  = count_q * thickness;
	assign idx_sq = count_q * count_q;
	assign t_sq   = thickness * thickness;
	assign enough = (count_q >= ttc_pkg::CNT_W'(ttc_pkg::MIN_SAMPLES));

	// Threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= ttc_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	// Accumulate each transfer up to the depth bound, else flag the drop; clear when the result is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			sxy_q   <= '0;
			syy_q   <= '0;
			sx_q    <= '0;
			sxx_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.out_load) begin
			count_q <= '0;
			sum_q   <= '0;
			sxy_q   <= '0;
			syy_q   <= '0;
			sx_q    <= '0;
			sxx_q   <= '0;
			drop_q  <= 1'b0;
		end else if (cmd.accept) begin
			if (full) begin
				drop_q <= 1'b1;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_q + ttc_pkg::SUM_W'(thickness);
				sxy_q   <= sxy_q + ttc_pkg::SXY_W'(idx_t);
				syy_q   <= syy_q + ttc_pkg::SYY_W'(t_sq);
				sx_q    <= sx_q + ttc_pkg::SX_W'(count_q);
				sxx_q   <= sxx_q + ttc_pkg::SXX_W'(idx_sq);
			end
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (cmd.mul_op)
			ttc_pkg::OP_N_SXY: begin
				mul_a = ttc_pkg::MUL_W'(count_q);
				mul_b = ttc_pkg::MUL_W'(sxy_q);
			end
			ttc_pkg::OP_SX_SY: begin
				mul_a = ttc_pkg::MUL_W'(sx_q);
				mul_b = ttc_pkg::MUL_W'(sum_q);
			end
			ttc_pkg::OP_N_SXX: begin
				mul_a = ttc_pkg::MUL_W'(count_q);
				mul_b = ttc_pkg::MUL_W'(sxx_q);
			end
			ttc_pkg::OP_SX_SX: begin
				mul_a = ttc_pkg::MUL_W'(sx_q);
				mul_b = ttc_pkg::MUL_W'(sx_q);
			end
			ttc_pkg::OP_N_SYY: begin
				mul_a = ttc_pkg::MUL_W'(count_q);
				mul_b = ttc_pkg::MUL_W'(syy_q);
			end
			ttc_pkg::OP_SY_SY: begin
				mul_a = ttc_pkg::MUL_W'(sum_q);
				mul_b = ttc_pkg::MUL_W'(sum_q);
			end
			ttc_pkg::OP_NUM_SQ: begin
				mul_a = num_q;
				mul_b = num_q;
			end
			default: begin
				mul_a = dx_q;
				mul_b = dy_q;
			end
		endcase
	end

	ttc_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	assign prod_lo = prod[ttc_pkg::MUL_W-1:0];

	// Capture each product where the next step needs it.
	always_ff @(posedge clk) begin
		if (mul_done) begin
			unique case (cmd.mul_op)
				ttc_pkg::OP_N_SXY, ttc_pkg::OP_N_SXX, ttc_pkg::OP_N_SYY: begin
					a_q <= prod_lo;
				end
				ttc_pkg::OP_SX_SY: begin
					neg_q <= (a_q < prod_lo);
					num_q <= (a_q < prod_lo) ? (prod_lo - a_q) : (a_q - prod_lo);
				end
				ttc_pkg::OP_SX_SX: begin
					dx_q <= a_q - prod_lo;
				end
				ttc_pkg::OP_SY_SY: begin
					dy_q      <= a_q - prod_lo;
					dy_zero_q <= (a_q == prod_lo);
				end
				ttc_pkg::OP_NUM_SQ: begin
					nn_q <= prod;
				end
				default: begin
					dd_q <= prod;
				end
			endcase
		end
	end

	// Divider operands: the mean, or the squared correlation scaled by 2^28.
	always_comb begin
		if (cmd.div_mean) begin
			div_num  = ttc_pkg::DIV_W'(sum_q);
			div_den  = ttc_pkg::DIV_W'(count_q) << (ttc_pkg::T_W - 1);
			div_last = ttc_pkg::QCNT_W'(ttc_pkg::T_W - 1);
		end else begin
			div_num  = ttc_pkg::DIV_W'(nn_q) << (2 * ttc_pkg::CORR_FRAC);
			div_den  = ttc_pkg::DIV_W'(dd_q) << (ttc_pkg::CQ_W - 1);
			div_last = ttc_pkg::QCNT_W'(ttc_pkg::CQ_W - 1);
		end
	end

	ttc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.num      (div_num),
		.den      (div_den),
		.last_bit (div_last),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			if (cmd.div_mean) begin
				mean_q <= div_quot[ttc_pkg::T_W-1:0];
			end else begin
				cq_q <= div_quot;
			end
		end
	end

	// Integer square root, one result bit per cycle from the top.
	assign cand    = root_q | sbit_q;
	assign cand_sq = cand * cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqrt_busy_q <= 1'b0;
			sqrt_done_q <= 1'b0;
		end else begin
			sqrt_done_q <= 1'b0;
			if (cmd.sqrt_start) begin
				sqrt_busy_q <= 1'b1;
			end else if (sqrt_busy_q && sbit_q[0]) begin
				sqrt_busy_q <= 1'b0;
				sqrt_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sqrt_start) begin
			root_q <= '0;
			sbit_q <= {1'b1, {(ttc_pkg::ROOT_W-1){1'b0}}};
		end else if (sqrt_busy_q) begin
			if (cand_sq <= (2*ttc_pkg::ROOT_W)'(cq_q)) begin
				root_q <= cand;
			end
			sbit_q <= sbit_q >> 1;
		end
	end

	// Result fields.
	assign qv        = dy_zero_q ? '0 : root_q;
	assign positive  = !neg_q && (num_q != '0) && !dy_zero_q;
	assign trend_hit = enough && (qv >= thr_q);
	assign corr      = (neg_q && !dy_zero_q) ? (ttc_pkg::CORR_W'(0) - ttc_pkg::CORR_W'(qv))
	                                         : ttc_pkg::CORR_W'(qv);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {4'b0000, drop_q, enough,
			               trend_hit && !positive, trend_hit && positive,
			               enough ? corr : ttc_pkg::CORR_W'(0),
			               enough ? mean_q : ttc_pkg::T_W'(0)};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.enough    = enough;
	assign status.dy_zero   = dy_zero_q;
	assign status.mul_done  = mul_done;
	assign status.div_done  = div_done;
	assign status.sqrt_done = sqrt_done_q;
	assign status.out_free  = !out_valid_q || out_ready;

endmodule
`default_nettype wire

/* sv/ttc_ctrl.sv */
`default_nettype none
module ttc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_last,
	output logic                      in_ready,
	input  wire ttc_pkg::ttc_status_t status,
	output ttc_pkg::ttc_cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_RUN,
		ST_CHK,
		ST_MUL_GO,
		ST_MUL_WAIT,
		ST_CHK_DY,
		ST_DIVQ_GO,
		ST_DIVQ_WAIT,
		ST_SQRT_GO,
		ST_SQRT_WAIT,
		ST_DIVM_GO,
		ST_DIVM_WAIT,
		ST_OUT
	} state_t;

	state_t           state_q;
	ttc_pkg::mul_op_t op_q;

	// Sequencer: gather a run, then walk the finishing steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			op_q    <= ttc_pkg::OP_N_SXY;
		end else begin
			unique case (state_q)
				ST_RUN: begin
					if (in_valid && in_last) begin
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					op_q    <= ttc_pkg::OP_N_SXY;
					state_q <= status.enough ? ST_MUL_GO : ST_OUT;
				end
				ST_MUL_GO: begin
					state_q <= ST_MUL_WAIT;
				end
				ST_MUL_WAIT: begin
					if (status.mul_done) begin
						if (op_q == ttc_pkg::OP_SY_SY) begin
							state_q <= ST_CHK_DY;
						end else if (op_q == ttc_pkg::OP_DX_DY) begin
							state_q <= ST_DIVQ_GO;
						end else begin
							op_q    <= ttc_pkg::mul_op_t'(op_q + 3'd1);
							state_q <= ST_MUL_GO;
						end
					end
				end
				ST_CHK_DY: begin
					if (status.dy_zero) begin
						state_q <= ST_DIVM_GO;
					end else begin
						op_q    <= ttc_pkg::OP_NUM_SQ;
						state_q <= ST_MUL_GO;
					end
				end
				ST_DIVQ_GO: begin
					state_q <= ST_DIVQ_WAIT;
				end
				ST_DIVQ_WAIT: begin
					if (status.div_done) begin
						state_q <= ST_SQRT_GO;
					end
				end
				ST_SQRT_GO: begin
					state_q <= ST_SQRT_WAIT;
				end
				ST_SQRT_WAIT: begin
					if (status.sqrt_done) begin
						state_q <= ST_DIVM_GO;
					end
				end
				ST_DIVM_GO: begin
					state_q <= ST_DIVM_WAIT;
				end
				ST_DIVM_WAIT: begin
					if (status.div_done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (status.out_free) begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Command decode from the current state.
	assign in_ready       = (state_q == ST_RUN);
	assign cmd.accept     = (state_q == ST_RUN) && in_valid;
	assign cmd.mul_start  = (state_q == ST_MUL_GO);
	assign cmd.mul_op     = op_q;
	assign cmd.div_start  = (state_q == ST_DIVQ_GO) || (state_q == ST_DIVM_GO);
	assign cmd.div_mean   = (state_q == ST_DIVM_GO) || (state_q == ST_DIVM_WAIT);
	assign cmd.sqrt_start = (state_q == ST_SQRT_GO);
	assign cmd.out_load   = (state_q == ST_OUT) && status.out_free;

endmodule
`default_nettype wire

/* sv/thickness_trend_correlation.sv */
// Channel   Direction  Transfer carries
// s_*       in         one thickness sample; tlast ends the run
// m_*       out        one result per run: mean, correlation and flags
// cfg_*     in         trend threshold, written with cfg_we
//
// During a run one sample is taken each cycle into exact running sums.
// After the last sample the input stalls while the result is finished:
// up to eight serial multiplies on the shared shift-add unit, each shorter
// for a shorter second operand (at most 59 bits), a 29-step and a 16-step
// restoring divide and a 15-step root; zero thickness variance skips the
// last two multiplies, the 29-step divide and the root. Runs shorter than
// three samples skip all of it. Reset clears the sums and sets the
// threshold to 8192. A finished result held on a stalled m_* lets the
// next run start; that run waits after its finish until the result leaves.
`default_nettype none
module thickness_trend_correlation (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	// thickness[15:0]
	input  wire logic [15:0]               s_tdata,
	input  wire logic                      s_tlast,
	output logic                           m_tvalid,
	input  wire logic                      m_tready,
	// mean[15:0], correlation[31:16], thickening flag[32],
	// thinning flag[33], enough samples[34], overflow[35], zero pad
	output logic [ttc_pkg::OUT_W-1:0]      m_tdata,
	input  wire logic                      cfg_we,
	input  wire logic [ttc_pkg::THR_W-1:0] cfg_wdata
);

	ttc_pkg::ttc_cmd_t    cmd;
	ttc_pkg::ttc_status_t status;

	ttc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_last  (s_tlast),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	ttc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.thickness (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef SYNTHESIS
	// The correlation never exceeds one in magnitude.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[31:16]) <= 16'sd16384 &&
		              $signed(m_tdata[31:16]) >= -16'sd16384))
		else $error("correlation out of range");

	// A trend is thickening or thinning, never both.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[32] && m_tdata[33]))
		else $error("both trend flags set");

	// A short run reports nothing but the drop flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[34]) |-> (m_tdata[33:0] == 34'd0))
		else $error("short run result not zero");

	// Once the last sample of a run is taken, the input stops being ready.
	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("sample taken during finish");
`endif

endmodule
`default_nettype wire

/* tb/sv/thickness_trend_correlation_test.sv */
`default_nettype none
module thickness_trend_correlation_test;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct {
		logic [15:0] mean_val;
		logic [15:0] correlation;
		logic        thick_flag;
		logic        thin_flag;
		logic        enough_samples;
		logic        overflowed;
	} trend_result_t;

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [15:0]                   s_tdata;
	logic                          s_tlast;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [ttc_pkg::OUT_W-1:0]     m_tdata;
	logic                          cfg_we;
	logic [ttc_pkg::THR_W-1:0]     cfg_wdata;

	// Model of the block: configuration and the running sums of the open run.
	logic [ttc_pkg::THR_W-1:0]     model_threshold;
	int unsigned          run_count;
	longint unsigned      run_sum;
	longint unsigned      run_weighted;
	longint unsigned      run_squares;
	bit                   run_dropped;
	trend_result_t        pending_results[$];

	int    error_count;
	int    results_seen;
	int    samples_sent;
	int    runs_sent;
	int    cycle_count;
	bit    no_idle;
	bit    hold_request;
	bit    holding;
	int    hold_left;

	thickness_trend_correlation dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Close the open run: mean and exact truncated correlation from the sums.
	function automatic trend_result_t close_run();
		trend_result_t r;
		bit [191:0] n, sx, sxx, a, b, num, dx, dy, dxy, rhs;
		bit         neg;
		int         lo, hi, mid, q;
		r = '{default: '0};
		r.overflowed = run_dropped;
		if (run_count >= ttc_pkg::MIN_SAMPLES) begin
			n   = run_count;
			sx  = n * (n - 1) / 2;
			sxx = (n - 1) * n * (2 * n - 1) / 6;
			a   = n * run_weighted;
			b   = sx * run_sum;
			neg = a < b;
			num = neg ? b - a : a - b;
			dx  = n * sxx - sx * sx;
			dy  = n * run_squares - 192'(run_sum) * run_sum;
			r.enough_samples = 1'b1;
			r.mean_val = 16'(run_sum / run_count);
			q = 0;
			if (dy != 0) begin
				dxy = dx * dy;
				rhs = (num * num) << 28;
				lo = 0;
				hi = 16384;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					if (192'(mid * mid) * dxy <= rhs)
						lo = mid;
					else
						hi = mid - 1;
				end
				q = lo;
			end else begin
				neg = 1'b0;
			end
			r.correlation = neg ? 16'(-q) : 16'(q);
			if (q >= model_threshold) begin
				if (!neg && num != 0)
					r.thick_flag = 1'b1;
				else
					r.thin_flag = 1'b1;
			end
		end
		return r;
	endfunction

	// Send one sample; the model takes it at the edge where it transfers.
	task automatic send_sample(input logic [15:0] thickness, input bit last);
		int gap;
		gap = (!no_idle && $urandom_range(99) < 38) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= thickness;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		if (run_count < ttc_pkg::MAX_SAMPLES) begin
			run_sum      += thickness;
			run_weighted += longint'(run_count) * thickness;
			run_squares  += longint'(thickness) * thickness;
			run_count++;
		end else begin
			run_dropped = 1'b1;
		end
		samples_sent++;
		if (last) begin
			pending_results = {pending_results, close_run()};
			run_count = 0;
			run_sum = 0;
			run_weighted = 0;
			run_squares = 0;
			run_dropped = 1'b0;
			runs_sent++;
		end
	endtask

	task automatic finish_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every result has come back, then let the clock run on before returning.
	task automatic wait_drained();
		finish_sending();
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [ttc_pkg::THR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_threshold = value;
		@(posedge clk);
	endtask

	task automatic send_run(input logic [15:0] samples[$]);
		foreach (samples[i])
			send_sample(samples[i], i == samples.size() - 1);
	endtask

	// Short runs, zero variance, clear trends both ways and field extremes.
	task automatic test_directed();
		send_run('{16'hFFFF});
		send_run('{16'h0000, 16'hFFFF});
		send_run('{16'd500, 16'd500, 16'd500});
		send_run('{16'h0000, 16'h8000, 16'hFFFF});
		send_run('{16'hFFFF, 16'h7FFF, 16'h0000, 16'h0001});
		send_run('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000});
		wait_drained();
		write_threshold(ttc_pkg::THR_W'(0));
		send_run('{16'd500, 16'd500, 16'd500});
		send_run('{16'd10, 16'd20, 16'd10});
		wait_drained();
		write_threshold(ttc_pkg::THR_W'(16384));
		send_run('{16'd1, 16'd2, 16'd3});
		wait_drained();
		write_threshold(ttc_pkg::THR_W'(32767));
		send_run('{16'd3, 16'd2, 16'd1});
		wait_drained();
		write_threshold(ttc_pkg::THR_RESET);
	endtask

	// A run longer than the depth bound, including a dropped last sample.
	task automatic test_depth_bound();
		no_idle = 1'b1;
		for (int i = 0; i < ttc_pkg::MAX_SAMPLES + 4; i++)
			send_sample(16'((i * 37) ^ $urandom_range(255)),
				i == ttc_pkg::MAX_SAMPLES + 3);
		no_idle = 1'b0;
		wait_drained();
	endtask

	// The receiver holds off while short runs keep coming, so the input stalls.
	task automatic test_output_stall();
		hold_request = 1'b1;
		while (!holding)
			@(posedge clk);
		hold_request = 1'b0;
		for (int r = 0; r < 8; r++)
			for (int i = 0; i < 4; i++)
				send_sample(16'($urandom), i == 3);
		wait_drained();
	endtask

	// Random well-formed runs in several shapes, with random run lengths.
	task automatic test_random_runs(input int total);
		int          sent, len, shape, base, slope;
		logic [15:0] t;
		sent = 0;
		while (sent < total) begin
			case ($urandom_range(9))
				0:       len = $urandom_range(1, 2);
				1:       len = $urandom_range(20, 60);
				default: len = $urandom_range(3, 12);
			endcase
			shape = $urandom_range(3);
			base  = $urandom_range(65535);
			slope = $urandom_range(400) - 200;
			no_idle = sent < total / 4;
			for (int i = 0; i < len; i++) begin
				case (shape)
					0:       t = 16'(base + slope * i + $urandom_range(63));
					1:       t = 16'($urandom);
					2:       t = 16'(base);
					default: t = 16'($urandom_range(7));
				endcase
				send_sample(t, i == len - 1);
			end
			sent += len;
		end
		no_idle = 1'b0;
		wait_drained();
	endtask

	// Receiver: random stalls, the long hold-off, and the result check.
	always @(posedge clk) begin
		trend_result_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("unexpected result %h", m_tdata);
				end else begin
					want = pending_results.pop_front();
					if (m_tdata[15:0] !== want.mean_val
							|| m_tdata[31:16] !== want.correlation
							|| m_tdata[32] !== want.thick_flag
							|| m_tdata[33] !== want.thin_flag
							|| m_tdata[34] !== want.enough_samples
							|| m_tdata[35] !== want.overflowed) begin
						error_count++;
						if (error_count <= 10)
							$display("mismatch: mean %0d/%0d corr %0d/%0d flags %b%b%b%b/%b",
								want.mean_val, m_tdata[15:0],
								$signed(want.correlation), $signed(m_tdata[31:16]),
								want.overflowed, want.enough_samples,
								want.thin_flag, want.thick_flag, m_tdata[35:32]);
					end
				end
			end
			if (hold_request && !holding) begin
				holding = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (holding) begin
				m_tready <= 1'b0;
				hold_left--;
				if (hold_left == 0)
					holding = 1'b0;
			end else begin
				m_tready <= no_idle || $urandom_range(99) >= 38;
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		model_threshold = ttc_pkg::THR_RESET;
		run_count = 0;
		run_sum = 0;
		run_weighted = 0;
		run_squares = 0;
		run_dropped = 1'b0;
		error_count = 0;
		results_seen = 0;
		samples_sent = 0;
		runs_sent = 0;
		cycle_count = 0;
		no_idle = 1'b0;
		hold_request = 1'b0;
		holding = 1'b0;
		hold_left = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_depth_bound();
		test_output_stall();
		test_random_runs(200);
		write_threshold(ttc_pkg::THR_W'(0));
		test_random_runs(100);
		write_threshold(ttc_pkg::THR_W'(16384));
		test_random_runs(100);
		write_threshold(ttc_pkg::THR_W'($urandom_range(1, 16383)));
		test_random_runs(100);

		repeat (700) @(posedge clk);
		$display("covered %0d samples in %0d runs, %0d results checked, %0d errors",
			samples_sent, runs_sent, results_seen, error_count);
		$display("thresholds from 0 to 32767, depth overflow and a long output hold-off");
		if (error_count == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
sv/ttc_pkg.sv
sv/ttc_mul.sv
sv/ttc_div.sv
sv/ttc_datapath.sv
sv/ttc_ctrl.sv
sv/thickness_trend_correlation.sv
tb/sv/thickness_trend_correlation_test.sv
